>>> rtl/cbed_pkg.sv
// ----------------------------------------------------------------------------
// cbed_pkg
// Shared types, codes and defaults for the counter based event debounce core.
// ----------------------------------------------------------------------------
package cbed_pkg;

	localparam int EVENT_COUNT_DEF = 256;

	// operation codes
	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_RESET  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// event status codes
	localparam logic [2:0] ST_INVALID   = 3'd0;
	localparam logic [2:0] ST_PASSED    = 3'd1;
	localparam logic [2:0] ST_FAILED    = 3'd2;
	localparam logic [2:0] ST_PREPASSED = 3'd3;
	localparam logic [2:0] ST_PREFAILED = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_PASSED_THR = 3'd0;
	localparam logic [2:0] REG_FAILED_THR = 3'd1;
	localparam logic [2:0] REG_JUMP_DOWN  = 3'd2;
	localparam logic [2:0] REG_JUMP_UP    = 3'd3;
	localparam logic [2:0] REG_JD_EN      = 3'd4;
	localparam logic [2:0] REG_JU_EN      = 3'd5;
	localparam logic [2:0] REG_ONLY_LIMIT = 3'd6;

	localparam logic signed [7:0] FDC_MAX = 8'sd127;
	localparam logic signed [7:0] FDC_MIN = -8'sd128;

	typedef struct packed {
		logic signed [15:0] passed_thr;
		logic [14:0]        failed_thr;
		logic signed [15:0] jump_down;
		logic signed [15:0] jump_up;
		logic               jd_en;
		logic               ju_en;
		logic               only_at_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [15:0] level;
	} entry_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] step;
		logic               clr;
		logic               ok;
	} item_t;

	typedef struct packed {
		logic   accepted;
		logic   fin;
		logic   we;
		entry_t nxt;
	} upd_t;

endpackage

>>> rtl/cbed_store.sv
// ----------------------------------------------------------------------------
// cbed_store
// Per-event entry memory (status and level), one read and one write port,
// registered read. Valid bits make unwritten entries read as zero/invalid.
// ----------------------------------------------------------------------------
module cbed_store import cbed_pkg::*; #(
	parameter int DEPTH  = EVENT_COUNT_DEF,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data
);

	entry_t mem [DEPTH];
	entry_t rd_q;
	logic   valid_q [DEPTH];
	logic   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

>>> rtl/cbed_update.sv
// ----------------------------------------------------------------------------
// cbed_update
// Next entry for one item: jump, step, clamp to thresholds, new status.
// ----------------------------------------------------------------------------
module cbed_update import cbed_pkg::*; (
	input  item_t  item,
	input  entry_t cur,
	input  cfg_t   cfg,
	output upd_t   upd
);

	logic signed [17:0] lvl_x, lo_x, hi_x, jd_x, ju_x, step_x, base_x, sum_x;
	logic signed [17:0] c1_x, c2_x;
	logic               step_neg, step_pos, at_lim, jump_dn, jump_up;
	logic [2:0]         ns;

	assign lvl_x  = {{2{cur.level[15]}}, cur.level};
	assign lo_x   = {{2{cfg.passed_thr[15]}}, cfg.passed_thr};
	assign hi_x   = {3'b000, cfg.failed_thr};
	assign jd_x   = {{2{cfg.jump_down[15]}}, cfg.jump_down};
	assign ju_x   = {{2{cfg.jump_up[15]}}, cfg.jump_up};
	assign step_x = {{2{item.step[15]}}, item.step};

	assign step_neg = item.step[15];
	assign step_pos = !item.step[15] && (item.step != 16'sd0);
	assign at_lim   = (lvl_x == lo_x && step_neg) || (lvl_x == hi_x && step_pos);

	assign jump_dn = step_neg && (cur.status == ST_PREFAILED || cur.status == ST_FAILED) &&
		cfg.jd_en && (lvl_x > jd_x) && (lvl_x == hi_x || !cfg.only_at_limit);
	assign jump_up = step_pos && (cur.status == ST_PREPASSED || cur.status == ST_PASSED) &&
		cfg.ju_en && (lvl_x < ju_x) && (lvl_x == lo_x || !cfg.only_at_limit);

	assign base_x = jump_dn ? jd_x : (jump_up ? ju_x : lvl_x);
	assign sum_x  = base_x + step_x;

	// passed clamp first, failed clamp second: the later one wins
	always_comb begin
		ns   = ST_INVALID;
		c1_x = sum_x;
		if (sum_x <= lo_x) begin
			c1_x = lo_x;
			ns   = ST_PASSED;
		end else if (sum_x < 18'sd0) begin
			ns = ST_PREPASSED;
		end
		c2_x = c1_x;
		if (c1_x >= hi_x) begin
			c2_x = hi_x;
			ns   = ST_FAILED;
		end else if (c1_x > 18'sd0) begin
			ns = ST_PREFAILED;
		end
	end

	always_comb begin
		upd.accepted = 1'b0;
		upd.fin      = 1'b0;
		upd.we       = 1'b0;
		upd.nxt      = cur;
		case (item.op)
			OP_REPORT: begin
				if (item.ok) begin
					upd.accepted = 1'b1;
					if (!at_lim) begin
						upd.we         = 1'b1;
						upd.nxt.level  = c2_x[15:0];
						upd.nxt.status = ns;
						upd.fin        = (ns == ST_PASSED) || (ns == ST_FAILED);
					end
				end
			end
			OP_RESET: begin
				upd.accepted   = 1'b1;
				upd.we         = 1'b1;
				upd.nxt.status = ST_INVALID;
				if (item.clr) begin
					upd.nxt.level = 16'sd0;
				end
			end
			OP_QUERY: begin
				upd.accepted = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/cbed_fdc.sv
// ----------------------------------------------------------------------------
// cbed_fdc
// Fault detection counter: level scaled by 127/failed or -128/passed threshold.
// Start loads the operands, then an 8-bit restoring divide runs at four bits a cycle.
// ----------------------------------------------------------------------------
module cbed_fdc import cbed_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] level,
	input  logic signed [15:0] passed_thr,
	input  logic [14:0]        failed_thr,
	output logic               done,
	output logic signed [7:0]  fault_counter
);

	logic        pos, neg, bad, ovf;
	logic [15:0] mag, dvs;
	logic [22:0] num;

	logic        run_q, half_q, done_q;
	logic        neg_q, zero_q, sat_q;
	logic [22:0] rem_q, dsh_q;
	logic [7:0]  quo_q;

	logic [22:0] rem_n, dsh_n;
	logic [7:0]  quo_n;

	assign pos = !level[15] && (level != 16'sd0);
	assign neg = level[15];
	assign mag = neg ? 16'(-level) : level;
	// magnitude*127 as a shift and subtract for a positive level, else magnitude*128
	assign num = pos ? ({mag, 7'b0} - {7'b0, mag}) : {mag, 7'b0};
	assign dvs = pos ? {1'b0, failed_thr} : 16'(-passed_thr);
	assign bad = (pos && failed_thr == '0) || (neg && !passed_thr[15]);
	// quotient of 256 or more saturates either way
	assign ovf = {1'b0, num} >= {dvs, 8'b0};

	always_comb begin
		rem_n = rem_q;
		dsh_n = dsh_q;
		quo_n = quo_q;
		for (int k = 0; k < 4; k++) begin
			if (rem_n >= dsh_n) begin
				rem_n = rem_n - dsh_n;
				quo_n = {quo_n[6:0], 1'b1};
			end else begin
				quo_n = {quo_n[6:0], 1'b0};
			end
			dsh_n = dsh_n >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			half_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && half_q;
			if (start) begin
				run_q  <= 1'b1;
				half_q <= 1'b0;
			end else if (run_q) begin
				half_q <= 1'b1;
				if (half_q) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= {dvs, 7'b0};
			quo_q  <= '0;
			neg_q  <= neg;
			zero_q <= (level == 16'sd0);
			sat_q  <= bad || ovf;
		end else if (run_q) begin
			rem_q <= rem_n;
			dsh_q <= dsh_n;
			quo_q <= quo_n;
		end
	end

	always_comb begin
		if (zero_q) begin
			fault_counter = 8'sd0;
		end else if (neg_q) begin
			fault_counter = (sat_q || quo_q > 8'd128) ? FDC_MIN : 8'(-quo_q);
		end else begin
			fault_counter = (sat_q || quo_q[7]) ? FDC_MAX : quo_q;
		end
	end

	assign done = done_q;

endmodule

>>> rtl/counter_based_event_debounce_core.sv
// ----------------------------------------------------------------------------
// counter_based_event_debounce_core
// Counter based debouncing of up to EVENT_COUNT events (256 at most), one entry
// per event held in a synchronous memory and updated by read-modify-write.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------------
//  item in   start, busy          operation, event_index, step_value,
//                                 clear_level, conditions_ok
//  result    done (1 cycle)       accepted, event_status, debounce_level,
//                                 fault_counter, debounce_flags, final_report
//  config    cfg_we               cfg_addr, cfg_wdata
//
//  An item passes entry read, update and write-back, divider setup, the divide,
//  the divider done register and the result register. done is high in the first
//  cycle with busy low; a new item is taken only while busy is low, not before.
//  The result is shown for one cycle only; the receiver cannot stall it.
//  Reset clears all entries (level zero, status invalid) at once.
// ----------------------------------------------------------------------------
module counter_based_event_debounce_core import cbed_pkg::*; #(
	parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [7:0]         event_index,
	input  logic signed [15:0] step_value,
	input  logic               clear_level,
	input  logic               conditions_ok,
	output logic               done,
	output logic               accepted,
	output logic [2:0]         event_status,
	output logic signed [15:0] debounce_level,
	output logic signed [7:0]  fault_counter,
	output logic [3:0]         debounce_flags,
	output logic               final_report,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [15:0]        cfg_wdata
);

	localparam int MEM_DEPTH = (EVENT_COUNT < 256) ? EVENT_COUNT : 256;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam logic [1:0] S_FDC  = 2'd2;
	localparam logic [1:0] S_WAIT = 2'd3;

	logic [1:0]        state_q;
	cfg_t              cfg_q;
	item_t             item_q;
	logic              oor_q;
	logic [ADDR_W-1:0] addr_q;
	upd_t              upd, upd_q;
	entry_t            cur;
	logic              take;
	logic              fdc_done;
	logic signed [7:0] fdc_val;

	logic               done_q, accepted_q, final_q;
	logic [2:0]         status_q;
	logic signed [15:0] level_q;
	logic signed [7:0]  fdc_q;
	logic [3:0]         flags_q;

	assign busy = (state_q != S_IDLE);
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.passed_thr    <= -16'sd128;
			cfg_q.failed_thr    <= 15'd127;
			cfg_q.jump_down     <= 16'sd0;
			cfg_q.jump_up       <= 16'sd0;
			cfg_q.jd_en         <= 1'b0;
			cfg_q.ju_en         <= 1'b0;
			cfg_q.only_at_limit <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PASSED_THR: cfg_q.passed_thr    <= cfg_wdata;
				REG_FAILED_THR: cfg_q.failed_thr    <= cfg_wdata[14:0];
				REG_JUMP_DOWN:  cfg_q.jump_down     <= cfg_wdata;
				REG_JUMP_UP:    cfg_q.jump_up       <= cfg_wdata;
				REG_JD_EN:      cfg_q.jd_en         <= cfg_wdata[0];
				REG_JU_EN:      cfg_q.ju_en         <= cfg_wdata[0];
				REG_ONLY_LIMIT: cfg_q.only_at_limit <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.op   <= operation;
			item_q.step <= step_value;
			item_q.clr  <= clear_level;
			item_q.ok   <= conditions_ok;
			addr_q      <= event_index[ADDR_W-1:0];
			oor_q       <= ({9'd0, event_index} >= 17'(EVENT_COUNT));
		end
		if (state_q == S_UPD) begin
			upd_q <= upd;
		end
	end

	cbed_store #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (event_index[ADDR_W-1:0]),
		.rd_data (cur),
		.wr_en   (state_q == S_UPD && upd.we && !oor_q),
		.wr_addr (addr_q),
		.wr_data (upd.nxt)
	);

	cbed_update u_update (
		.item (item_q),
		.cur  (cur),
		.cfg  (cfg_q),
		.upd  (upd)
	);

	cbed_fdc u_fdc (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (state_q == S_FDC),
		.level         (upd_q.nxt.level),
		.passed_thr    (cfg_q.passed_thr),
		.failed_thr    (cfg_q.failed_thr),
		.done          (fdc_done),
		.fault_counter (fdc_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (take) state_q <= S_UPD;
				S_UPD:  state_q <= S_FDC;
				S_FDC:  state_q <= S_WAIT;
				S_WAIT: begin
					if (fdc_done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register; an out-of-range index reports all zero
	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && fdc_done) begin
			if (oor_q) begin
				accepted_q <= 1'b0;
				status_q   <= ST_INVALID;
				level_q    <= 16'sd0;
				fdc_q      <= 8'sd0;
				flags_q    <= 4'd0;
				final_q    <= 1'b0;
			end else begin
				accepted_q <= upd_q.accepted;
				status_q   <= upd_q.nxt.status;
				level_q    <= upd_q.nxt.level;
				fdc_q      <= fdc_val;
				flags_q[0] <= (fdc_val > 8'sd0) && (fdc_val != FDC_MAX);
				flags_q[1] <= (fdc_val == FDC_MAX);
				flags_q[2] <= (fdc_val < 8'sd0) && (fdc_val != FDC_MIN);
				flags_q[3] <= (fdc_val == FDC_MAX) || (fdc_val == FDC_MIN);
				final_q    <= upd_q.fin;
			end
		end
	end

	assign done           = done_q;
	assign accepted       = accepted_q;
	assign event_status   = status_q;
	assign debounce_level = level_q;
	assign fault_counter  = fdc_q;
	assign debounce_flags = flags_q;
	assign final_report   = final_q;

endmodule

>>> rtl/cbed_checker.sv
// ----------------------------------------------------------------------------
// cbed_checker
// Port-level checks on the debounce core's item and result channels.
// ----------------------------------------------------------------------------
module cbed_checker import cbed_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              accepted,
	input logic [2:0]        event_status,
	input logic signed [7:0] fault_counter,
	input logic [3:0]        debounce_flags,
	input logic              final_report
);

	// an accepted item always occupies the core
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("core not busy after taking an item");

	// one result per item, shown for a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		done && final_report |->
			accepted && (event_status == ST_PASSED || event_status == ST_FAILED))
		else $error("final report without passed or failed status");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && debounce_flags[1] |-> fault_counter == FDC_MAX && debounce_flags[3])
		else $error("final defective flag inconsistent with fault counter");

endmodule

bind counter_based_event_debounce_core cbed_checker u_cbed_checker (.*);
